// ===== rtl/swb_weyl_random_generator_core_macros.svh =====
// ----------------------------------------------------------------------------
// swb_weyl_random_generator_core_macros.svh
// Assertion macros used by the checker of the random word generator.
// ----------------------------------------------------------------------------
`ifndef SWB_WEYL_RANDOM_GENERATOR_CORE_MACROS_SVH
`define SWB_WEYL_RANDOM_GENERATOR_CORE_MACROS_SVH

// Check a property at every rising edge outside reset.
`define SWB_ASSERT_ON(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising edge, reset cycles included.
`define SWB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/swbwrg_pkg.sv =====
// ----------------------------------------------------------------------------
// swbwrg_pkg
// Types and fixed constants of the subtract-with-borrow / Weyl generator.
// ----------------------------------------------------------------------------
package swbwrg_pkg;

  // Field widths of one transaction
  localparam int WORD_W  = 32;
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 6;

  // Arithmetic constants
  localparam logic [WORD_W-1:0] SWB_MODULUS = 32'hFFFF_FFFB;  // 4294967291
  localparam logic [WORD_W-1:0] WEYL_STEP   = 32'd362436069;
  localparam int                SHORT_LAG   = 22;

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_GENERATE   = 2'd0,
    CMD_LOAD_ENTRY = 2'd1,
    CMD_LOAD_WEYL  = 2'd2
  } cmd_t;

endpackage

// ===== rtl/swbwrg_ram.sv =====
// ----------------------------------------------------------------------------
// swbwrg_ram
// Generic RAM: one write port, two read ports, registered read data.
// A read in the same cycle as a write to that entry returns the old word.
// ----------------------------------------------------------------------------
module swbwrg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 43
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== rtl/swb_weyl_random_generator_core.sv =====
// ----------------------------------------------------------------------------
// swb_weyl_random_generator_core
// Subtract-with-borrow (lags 43/22, modulus 4294967291) plus Weyl generator.
//
// Input channel (item_valid / item_stall): cmd selects generate, load of one
// lag table entry (entry_index, load_value saturated at 4294967291), or load
// of the Weyl word, which also resets both positions and sets the borrow.
// Output channel (word_valid / word_stall): one random_word per generate;
// load commands and the unused command give no output.
// Throughput: one transaction per cycle while item_stall is low. Each
// generate reads two table words and writes one, all through the one table
// RAM (two read ports, one write). A generate's table words are read as it
// enters the compute stage; its result is registered in random_word.
// Reset: positions start so the first generate uses entries 43 and 22, the
// borrow is one, the Weyl word is zero; the table is not cleared and must be
// loaded before use. A stalled output holds its word; the block keeps taking
// transactions until a generate waits for the output, then stalls the input.
// ----------------------------------------------------------------------------
module swb_weyl_random_generator_core import swbwrg_pkg::*; #(
  parameter int LAG_LENGTH = 43
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [WORD_W-1:0]  load_value,
  output logic               word_valid,
  input  logic               word_stall,
  output logic [WORD_W-1:0]  random_word
);

  localparam int ADDR_W = $clog2(LAG_LENGTH);
  localparam int POS_W  = $clog2(LAG_LENGTH + 2);
  localparam logic [POS_W-1:0] LONG_START  = POS_W'(LAG_LENGTH + 1);
  localparam logic [POS_W-1:0] SHORT_START = POS_W'(SHORT_LAG + 1);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(LAG_LENGTH);

  // Move a one-based circular position back by one, wrapping to the last entry
  function automatic logic [POS_W-1:0] step_back(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] q;
    q = p - POS_W'(1);
    if (p == '0 || p > LONG_START || q == '0) begin
      q = POS_LAST;
    end
    return q;
  endfunction

  // Generator state
  logic [POS_W-1:0]  long_pos;
  logic [POS_W-1:0]  short_pos;
  logic [WORD_W-1:0] weyl;
  logic              borrow;

  // Compute stage
  logic              s1_valid;
  cmd_t              s1_cmd;
  logic [ADDR_W-1:0] s1_long_addr;
  logic [ADDR_W-1:0] s1_short_addr;
  logic [WORD_W-1:0] s1_data;

  // Last table write, for reads that overlap it
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  logic [WORD_W-1:0] fwd_data;

  logic              accept;
  logic              item_keep;
  cmd_t              in_cmd;
  logic [POS_W-1:0]  long_step;
  logic [POS_W-1:0]  short_step;
  logic [POS_W-1:0]  long_idx;
  logic [POS_W-1:0]  short_idx;
  logic [ADDR_W-1:0] long_rd_addr;
  logic [ADDR_W-1:0] short_rd_addr;
  logic [WORD_W-1:0] weyl_step;
  logic [WORD_W-1:0] load_sat;

  logic              out_free;
  logic              s1_go;
  logic              s1_free;
  logic [WORD_W-1:0] rd_long;
  logic [WORD_W-1:0] rd_short;
  logic [WORD_W-1:0] lag_long;
  logic [WORD_W-1:0] lag_short;
  logic [WORD_W:0]   hold;
  logic [WORD_W+1:0] diff;
  logic              under;
  logic [WORD_W-1:0] gen_word;
  logic [WORD_W-1:0] gen_out;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;

  // Handshake
  assign out_free   = !word_valid || !word_stall;
  assign s1_go      = s1_valid && (s1_cmd != CMD_GENERATE || out_free);
  assign s1_free    = !s1_valid || s1_go;
  assign item_stall = !s1_free;
  assign accept     = item_valid && !item_stall;
  assign in_cmd     = cmd_t'(cmd);

  // Next positions and table read addresses
  assign long_step     = step_back(long_pos);
  assign short_step    = step_back(short_pos);
  assign long_idx      = long_step - POS_W'(1);
  assign short_idx     = short_step - POS_W'(1);
  assign long_rd_addr  = long_idx[ADDR_W-1:0];
  assign short_rd_addr = short_idx[ADDR_W-1:0];
  assign weyl_step     = weyl - WEYL_STEP;
  assign load_sat      = (load_value > SWB_MODULUS) ? SWB_MODULUS : load_value;

  // Decide whether the transaction needs the compute stage
  always_comb begin
    unique case (in_cmd)
      CMD_GENERATE:   item_keep = 1'b1;
      CMD_LOAD_ENTRY: item_keep = (entry_index < INDEX_W'(LAG_LENGTH));
      CMD_LOAD_WEYL:  item_keep = 1'b1;
      default:        item_keep = 1'b0;
    endcase
  end

  // Advance positions and the Weyl word on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      long_pos  <= LONG_START;
      short_pos <= SHORT_START;
      weyl      <= '0;
    end else if (accept) begin
      unique case (in_cmd)
        CMD_GENERATE: begin
          long_pos  <= long_step;
          short_pos <= short_step;
          weyl      <= weyl_step;
        end
        CMD_LOAD_WEYL: begin
          long_pos  <= LONG_START;
          short_pos <= SHORT_START;
          weyl      <= load_value;
        end
        default: begin
        end
      endcase
    end
  end

  // Load the compute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept && item_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd        <= in_cmd;
      s1_short_addr <= short_rd_addr;
      if (in_cmd == CMD_LOAD_ENTRY) begin
        s1_long_addr <= entry_index[ADDR_W-1:0];
        s1_data      <= load_sat;
      end else begin
        s1_long_addr <= long_rd_addr;
        s1_data      <= weyl_step;
      end
    end
  end

  // Lag table
  swbwrg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LAG_LENGTH)
  ) u_lag_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (s1_long_addr),
    .wr_data   (wr_data),
    .rd_en     (s1_free),
    .rd_addr_a (long_rd_addr),
    .rd_addr_b (short_rd_addr),
    .rd_data_a (rd_long),
    .rd_data_b (rd_short)
  );

  // Forward the write that landed in the same cycle as the read
  assign lag_long  = (fwd_valid && fwd_addr == s1_long_addr)  ? fwd_data : rd_long;
  assign lag_short = (fwd_valid && fwd_addr == s1_short_addr) ? fwd_data : rd_short;

  // Subtract with borrow modulo the prime, then remove the Weyl word
  assign hold     = {1'b0, lag_long} + {{WORD_W{1'b0}}, borrow};
  assign diff     = {2'b00, lag_short} - {1'b0, hold};
  assign under    = diff[WORD_W+1];
  assign gen_word = under ? (diff[WORD_W-1:0] + SWB_MODULUS) : diff[WORD_W-1:0];
  assign gen_out  = gen_word - s1_data;

  // Write back
  assign wr_en   = s1_go && (s1_cmd == CMD_GENERATE || s1_cmd == CMD_LOAD_ENTRY);
  assign wr_data = (s1_cmd == CMD_GENERATE) ? gen_word : s1_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= s1_long_addr;
      fwd_data <= wr_data;
    end
  end

  // Update the borrow
  always_ff @(posedge clk) begin
    if (rst) begin
      borrow <= 1'b1;
    end else if (s1_go) begin
      unique case (s1_cmd)
        CMD_GENERATE:  borrow <= under;
        CMD_LOAD_WEYL: borrow <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (s1_go && s1_cmd == CMD_GENERATE) begin
      word_valid <= 1'b1;
    end else if (!word_stall) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_cmd == CMD_GENERATE) begin
      random_word <= gen_out;
    end
  end

endmodule

// ===== rtl/swbwrg_checker.sv =====
// ----------------------------------------------------------------------------
// swbwrg_checker
// Port-level checks of the random word generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "swb_weyl_random_generator_core_macros.svh"

module swbwrg_checker import swbwrg_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input logic [CMD_W-1:0]   cmd,
  input logic               word_valid,
  input logic               word_stall,
  input logic [WORD_W-1:0]  random_word
);

  logic out_wait;
  logic gen_accept;

  assign out_wait   = word_valid && word_stall;
  assign gen_accept = item_valid && !item_stall && (cmd == CMD_GENERATE);

  // Hold a stalled transaction
  `SWB_ASSERT_ON(a_out_hold_valid, clk, rst, out_wait |=> word_valid, "valid dropped in stall")
  `SWB_ASSERT_ON(a_out_hold_word, clk, rst, out_wait |=> $stable(random_word), "word moved in stall")

  // Reset empties the output
  `SWB_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !word_valid, "output valid after reset")

  // A fresh word must come from an accepted generate
  `SWB_ASSERT_ON(a_word_latency, clk, rst, $rose(word_valid) |-> $past(gen_accept, 2), "stray word")

endmodule

bind swb_weyl_random_generator_core swbwrg_checker u_swbwrg_checker (.*);
